// File: rtl/hamming_nearest_descriptor_match_assert.svh
// assertion macros used by the checker file of the descriptor matcher
// needs nothing else; the including file supplies clock, reset and signals
`ifndef HAMMING_NEAREST_DESCRIPTOR_MATCH_ASSERT_SVH
`define HAMMING_NEAREST_DESCRIPTOR_MATCH_ASSERT_SVH

// same-cycle implication, off while reset is low
`define HNDM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define HNDM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also checks during reset
`define HNDM_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hndm_pkg.sv
// shared types and constants of the hamming descriptor matcher
// used by every module of the block but the ram; depends on nothing
package hndm_pkg;

    localparam int WORD_W    = 64;
    localparam int DESC_BITS = 256;
    localparam int DESC_WORDS = DESC_BITS / WORD_W;
    localparam int IDX_W     = 10;
    localparam int DIST_W    = 9;
    localparam int BYTES     = DESC_BITS / 8;
    localparam int GROUPS    = 4;
    localparam int PER_GROUP = BYTES / GROUPS;
    localparam int GRP_W     = 7;

    localparam logic [1:0] LAST_WORD = 2'(DESC_WORDS - 1);

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam logic [DIST_W-1:0] START_RESET  = 9'd128;
    localparam logic [DIST_W-1:0] ACCEPT_RESET = 9'd80;

    // configuration register indexes
    localparam logic [0:0] CFG_START  = 1'b0;
    localparam logic [0:0] CFG_ACCEPT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QWORD = 2'd1,
        CMD_QLAST = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IDX_W-1:0]   entry;
        logic [1:0]         word;
        logic [WORD_W-1:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [DIST_W-1:0] start_distance;
        logic [DIST_W-1:0] accept_limit;
    } cfg_t;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

endpackage

// File: rtl/hndm_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module hndm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/hndm_front.sv
// input side: decodes each item and turns each kept one into a queue command
// depends on hndm_pkg
module hndm_front import hndm_pkg::*; #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);
    localparam logic [16:0] MaxEnt = 17'(MAX_ENTRIES);

    op_t       op;
    cmd_kind_t kind;
    logic      keep;

    assign op       = op_t'(s_tuser);
    assign s_tready = !q_full;

    // field split: entry, word, data from low bits up
    assign q_cmd = '{kind:  kind,
                     entry: s_tdata[9:0],
                     word:  s_tdata[11:10],
                     data:  s_tdata[75:12]};

    // classify; out-of-range loads and unknown codes are dropped here
    always_comb begin
        keep = 1'b0;
        kind = CMD_LOAD;
        unique case (op)
            OP_LOAD: begin
                keep = 17'(s_tdata[9:0]) < MaxEnt;
                kind = CMD_LOAD;
            end
            OP_QUERY: begin
                keep = 1'b1;
                kind = (s_tdata[11:10] == LAST_WORD) ? CMD_QLAST : CMD_QWORD;
            end
            OP_CLEAR: begin
                keep = 1'b1;
                kind = CMD_CLEAR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = s_tvalid && s_tready && keep;
endmodule

// File: rtl/hndm_cmd_fifo.sv
// short command queue that decouples front and back
// depends on hndm_pkg
module hndm_cmd_fifo import hndm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);
    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

// File: rtl/hndm_back.sv
// execution side: table writes, query buffer, the distance walk and the result register
// depends on hndm_pkg and hndm_ram
module hndm_back import hndm_pkg::*; #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  q_cmd,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  cfg_t                  cfg,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);
    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int EXT = (EW > IDX_W) ? EW : IDX_W;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN} state_t;

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [EW-1:0]          walk_idx_reg, walk_idx_next;
    logic [DIST_W-1:0]      best_dist_reg, best_dist_next;
    logic [EW-1:0]          best_idx_reg, best_idx_next;
    logic                   found_reg, found_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic                   s1_vld_reg, s2_vld_reg;

    logic [WORD_W-1:0]      qbuf_reg [DESC_WORDS];
    logic                   qbuf_we;
    logic                   ram_we, rd_en;
    logic [EW-1:0]          entry_addr;
    logic [EXT-1:0]         entry_ext, best_idx_ext;
    logic [WORD_W-1:0]      rd_word [DESC_WORDS];
    logic [DESC_BITS-1:0]   diff;
    logic [EW-1:0]          rd_idx_reg, s1_idx_reg, s2_idx_reg;
    logic [3:0]             s1_cnt_reg [BYTES];
    logic [GRP_W-1:0]       s2_sum_reg [GROUPS];
    logic [GRP_W-1:0]       grp_sum [GROUPS];
    logic [DIST_W-1:0]      walk_dist;
    logic                   is_match;

    assign entry_ext  = EXT'(q_cmd.entry);
    assign entry_addr = entry_ext[EW-1:0];

    // one bank per descriptor quarter, all read at the walk index
    for (genvar b = 0; b < DESC_WORDS; b++) begin : g_bank
        hndm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES)) u_ram (
            .aclk  (aclk),
            .we    (ram_we && (q_cmd.word == 2'(b))),
            .waddr (entry_addr),
            .wdata (q_cmd.data),
            .re    (rd_en),
            .raddr (walk_idx_reg),
            .rdata (rd_word[b])
        );
        assign diff[b*WORD_W +: WORD_W] = rd_word[b] ^ qbuf_reg[b];
    end

    // query buffer
    always_ff @(posedge aclk) begin
        if (qbuf_we) begin
            qbuf_reg[q_cmd.word] <= q_cmd.data;
        end
    end

    // distance pipeline: byte counts, then group sums
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_sum[g] = '0;
            for (int k = 0; k < PER_GROUP; k++) begin
                grp_sum[g] = grp_sum[g] + GRP_W'(s1_cnt_reg[g*PER_GROUP + k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= walk_idx_reg;
        s1_idx_reg <= rd_idx_reg;
        s2_idx_reg <= s1_idx_reg;
        for (int i = 0; i < BYTES; i++) begin
            s1_cnt_reg[i] <= pop8(diff[i*8 +: 8]);
        end
        for (int g = 0; g < GROUPS; g++) begin
            s2_sum_reg[g] <= grp_sum[g];
        end
    end

    // final sum of the four group counts
    assign walk_dist = DIST_W'(s2_sum_reg[0]) + DIST_W'(s2_sum_reg[1])
                     + DIST_W'(s2_sum_reg[2]) + DIST_W'(s2_sum_reg[3]);

    assign is_match     = found_reg && (best_dist_reg < cfg.accept_limit);
    assign best_idx_ext = EXT'(best_idx_reg);

    // command sequencing and walk control
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        walk_idx_next  = walk_idx_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        rd_vld_next    = 1'b0;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        qbuf_we        = 1'b0;
        rd_en          = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // running minimum, first strictly smaller distance wins
        if (s2_vld_reg && (walk_dist < best_dist_reg)) begin
            best_dist_next = walk_dist;
            best_idx_next  = s2_idx_reg;
            found_next     = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && ((q_cmd.kind != CMD_QLAST) || !m_valid_reg)) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_LOAD: begin
                            ram_we = 1'b1;
                            if (q_cmd.word == LAST_WORD) begin
                                count_next = CW'(entry_addr) + CW'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            count_next = '0;
                        end
                        CMD_QWORD: begin
                            qbuf_we = 1'b1;
                        end
                        CMD_QLAST: begin
                            qbuf_we        = 1'b1;
                            best_dist_next = cfg.start_distance;
                            best_idx_next  = '0;
                            found_next     = 1'b0;
                            walk_idx_next  = '0;
                            state_next     = (count_reg == '0) ? ST_DRAIN : ST_WALK;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                rd_en       = 1'b1;
                rd_vld_next = 1'b1;
                if (CW'(walk_idx_reg) == count_reg - CW'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    walk_idx_next = walk_idx_reg + EW'(1);
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !s1_vld_reg && !s2_vld_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, best_dist_reg,
                                    best_idx_ext[IDX_W-1:0], is_match};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= rd_vld_next;
            s1_vld_reg  <= rd_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
        end
        walk_idx_reg  <= walk_idx_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        found_reg     <= found_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

// File: rtl/hamming_nearest_descriptor_match.sv
// top level of the hamming nearest-descriptor matcher
// depends on hndm_pkg, hndm_front, hndm_cmd_fifo, hndm_back
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata, s_tuser (operation)
//  m_        out        m_tvalid / m_tready  m_tdata (match, index, distance)
//  cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// loads, clears and non-final query words are each taken by the back end while idle
// a final query word walks the table at one entry per cycle from the four quarter
// banks, then waits for the distance pipeline to drain before the result shows on m_;
// an empty table skips the walk
// reset is synchronous; no clearing pass, the walk covers entries 0 up to the last loaded one
// the front keeps taking items into a two-deep queue until it fills, while the back
// walks or a result waits on m_tready
module hamming_nearest_descriptor_match import hndm_pkg::*; #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // entry_index, word_index, word_data, zero pad
    input  logic [IN_USER_W-1:0]  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // match_found, best_index, best_distance, pad
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [DIST_W-1:0]     cfg_wdata
);
    cfg_t cfg_reg;
    logic q_full, q_push, q_valid, q_pop;
    cmd_t push_cmd, pop_cmd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_distance <= START_RESET;
            cfg_reg.accept_limit   <= ACCEPT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START:  cfg_reg.start_distance <= cfg_wdata;
                CFG_ACCEPT: cfg_reg.accept_limit   <= cfg_wdata;
                default:    cfg_reg                <= cfg_reg;
            endcase
        end
    end

    hndm_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    hndm_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    hndm_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_cmd    (pop_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule

// File: rtl/hndm_checker.sv
// port-level checks of the descriptor matcher, bound to the top level
// depends on hndm_pkg and hamming_nearest_descriptor_match_assert.svh
`include "hamming_nearest_descriptor_match_assert.svh"

module hndm_checker import hndm_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic [IN_USER_W-1:0]  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  cfg_we,
    input logic [0:0]            cfg_index,
    input logic [DIST_W-1:0]     cfg_wdata
);
    logic [DIST_W-1:0] start_sh_reg;
    logic [DIST_W-1:0] accept_sh_reg;

    // shadow copies of the two registers as seen on the write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_sh_reg  <= START_RESET;
            accept_sh_reg <= ACCEPT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_START) begin
                start_sh_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_ACCEPT) begin
                accept_sh_reg <= cfg_wdata;
            end
        end
    end

    `HNDM_ASSERT_ALWAYS(a_reset_no_result, aclk, !aresetn, !m_tvalid, "result valid after reset")
    `HNDM_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `HNDM_ASSERT_NOW(a_dist_bound, aclk, aresetn, m_tvalid, m_tdata[19:11] <= start_sh_reg, "distance above start bound")
    `HNDM_ASSERT_NOW(a_match_limit, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[19:11] < accept_sh_reg, "match at or above accept limit")
endmodule

bind hamming_nearest_descriptor_match hndm_checker u_hndm_checker (.*);
